FILE: hdl/normal_matrix_inverse_3x3_defines.svh
// assertion macros for the normal matrix inverse block
`ifndef NORMAL_MATRIX_INVERSE_3X3_DEFINES_SVH
`define NORMAL_MATRIX_INVERSE_3X3_DEFINES_SVH

`ifndef SYNTHESIS
`define NMI_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
`define NMI_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define NMI_ASSERT_NOW(lbl, ante, cons)
`define NMI_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

FILE: hdl/nmi_pkg.sv
// shared constants and types for the normal matrix inverse block
package nmi_pkg;

  localparam int unsigned NMI_DIM     = 3;
  localparam int unsigned NMI_ENTRIES = 9;

  // per-lane sign and saturation status of a divider lane
  typedef struct packed {
    logic neg;
    logic sat;
  } nmi_flag_t;

endpackage

FILE: hdl/nmi_if.sv
// matrix and result channel interfaces
interface nmi_mat_if #(parameter int ELEM_WIDTH = 32) ();
  logic valid;
  logic ready;
  logic signed [ELEM_WIDTH-1:0] a11, a21, a31, a12, a22, a32, a13, a23, a33;

  modport source (output valid, a11, a21, a31, a12, a22, a32, a13, a23, a33,
                  input ready);
  modport sink   (input valid, a11, a21, a31, a12, a22, a32, a13, a23, a33,
                  output ready);
endinterface

interface nmi_res_if #(parameter int ELEM_WIDTH = 32) ();
  logic valid;
  logic ready;
  logic signed [ELEM_WIDTH-1:0] b11, b21, b31, b12, b22, b32, b13, b23, b33;
  logic degenerate;
  logic overflow;

  modport source (output valid, b11, b21, b31, b12, b22, b32, b13, b23, b33,
                  degenerate, overflow, input ready);
  modport sink   (input valid, b11, b21, b31, b12, b22, b32, b13, b23, b33,
                  degenerate, overflow, output ready);
endinterface

FILE: hdl/nmi_div.sv
// pipelined restoring divider lane with rounding and saturation
module nmi_div import nmi_pkg::*; #(
  parameter int ELEM_WIDTH = 32,
  parameter int FRAC_BITS  = 16
) (
  input  logic                      clk,
  input  logic                      en,
  input  logic [2*ELEM_WIDTH-1:0]   num,
  input  logic [3*ELEM_WIDTH+1:0]   den,
  input  logic                      neg,
  output logic [ELEM_WIDTH-1:0]     quo,
  output nmi_flag_t                 flag
);

  localparam int W  = ELEM_WIDTH;
  localparam int NW = 2 * ELEM_WIDTH;
  localparam int MW = 3 * ELEM_WIDTH + 2;
  localparam int SW = NW + 2 * FRAC_BITS;
  localparam int HW = SW - ELEM_WIDTH;
  localparam int XW = MW + HW;
  localparam logic [W:0] QPOS = {2'b00, {(W-1){1'b1}}};
  localparam logic [W:0] QNEG = {2'b01, {(W-1){1'b0}}};

  logic [SW-1:0] nsh;
  logic [HW-1:0] hi;
  logic          hi_ovf;

  logic [MW-1:0] rem_r [W+1];
  logic [W-1:0]  lo_r  [W];
  logic [W-1:0]  q_r   [W+1];
  logic [MW-1:0] d_r   [W+1];
  nmi_flag_t     fl_r  [W+1];

  logic [W-1:0]  quo_r;
  nmi_flag_t     flag_r;

  assign nsh    = {num, {(2*FRAC_BITS){1'b0}}};
  assign hi     = nsh[SW-1:W];
  // quotient of 2^W or more saturates whatever the sign
  assign hi_ovf = XW'(hi) >= XW'(den);

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r[0] <= MW'(hi);
      lo_r[0]  <= nsh[W-1:0];
      q_r[0]   <= '0;
      d_r[0]   <= den;
      fl_r[0]  <= '{neg: neg, sat: hi_ovf};
    end
  end

  for (genvar j = 1; j <= W; j++) begin : g_step
    logic [MW:0] r2;
    logic [MW:0] dif;
    logic        ge;
    assign r2  = {rem_r[j-1], lo_r[j-1][W-1]};
    assign dif = r2 - {1'b0, d_r[j-1]};
    assign ge  = r2 >= {1'b0, d_r[j-1]};
    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[j] <= ge ? dif[MW-1:0] : r2[MW-1:0];
        q_r[j]   <= {q_r[j-1][W-2:0], ge};
        d_r[j]   <= d_r[j-1];
        fl_r[j]  <= fl_r[j-1];
      end
    end
    if (j < W) begin : g_lo
      always_ff @(posedge clk) begin
        if (en) begin
          lo_r[j] <= lo_r[j-1] << 1;
        end
      end
    end
  end

  logic          rnd;
  logic [W:0]    qf;
  logic          sat;

  // round half away from zero on the magnitude
  assign rnd = {rem_r[W], 1'b0} >= {1'b0, d_r[W]};
  assign qf  = {1'b0, q_r[W]} + (W+1)'(rnd);
  assign sat = fl_r[W].sat || (fl_r[W].neg ? (qf > QNEG) : (qf > QPOS));

  always_ff @(posedge clk) begin
    if (en) begin
      if (sat) begin
        quo_r <= fl_r[W].neg ? QNEG[W-1:0] : QPOS[W-1:0];
      end else begin
        quo_r <= fl_r[W].neg ? (-qf[W-1:0]) : qf[W-1:0];
      end
      flag_r <= '{neg: fl_r[W].neg, sat: sat};
    end
  end

  assign quo  = quo_r;
  assign flag = flag_r;

endmodule

FILE: hdl/normal_matrix_inverse_3x3.sv
// throughput: one matrix per cycle while the skid entry is empty, every stage including the ELEM_WIDTH+2 divider
// stages takes a new word each cycle unless the pipeline is stalled
// output register plus one skid entry; the whole pipeline stalls while both are full
// reset: synchronous active low, clears valid bits, sets the transpose select tr_r to 1, holds ready low
module normal_matrix_inverse_3x3 import nmi_pkg::*; #(
  parameter int ELEM_WIDTH = 32,
  parameter int FRAC_BITS  = 16
) (
  input  logic     clk,
  input  logic     rst_n,
  nmi_mat_if.sink  in_mat,
  nmi_res_if.source out_res,
  input  logic     cfg_we,
  input  logic     cfg_wdata
);

`include "normal_matrix_inverse_3x3_defines.svh"

  localparam int W  = ELEM_WIDTH;
  localparam int CW = 2 * ELEM_WIDTH + 1;
  localparam int LW = 2 * ELEM_WIDTH + 1;
  localparam int DW = 3 * ELEM_WIDTH + 3;
  localparam int MW = 3 * ELEM_WIDTH + 2;
  localparam int NW = 2 * ELEM_WIDTH;
  localparam int DL = ELEM_WIDTH + 2;
  localparam logic [W-1:0] ONE_Q = (FRAC_BITS <= ELEM_WIDTH - 2) ?
                                   (ELEM_WIDTH'(1) << FRAC_BITS) :
                                   {1'b0, {(ELEM_WIDTH-1){1'b1}}};
  localparam logic ID_OVF = (FRAC_BITS > ELEM_WIDTH - 2);

  logic en;
  logic tr_r;

  logic                v1_r, v2_r, v3_r, v4_r, v5_r, v6_r, v7_r;
  logic signed [W-1:0]    a1_r [NMI_DIM][NMI_DIM];
  logic signed [W-1:0]    a2_r [NMI_DIM];
  logic signed [W-1:0]    a3_r [NMI_DIM];
  logic signed [2*W-1:0]  p1_r [NMI_DIM][NMI_DIM];
  logic signed [2*W-1:0]  p2_r [NMI_DIM][NMI_DIM];
  logic signed [CW-1:0]   c3_r [NMI_DIM][NMI_DIM];
  logic signed [CW-1:0]   c4_r [NMI_DIM][NMI_DIM];
  logic signed [CW-1:0]   c5_r [NMI_DIM][NMI_DIM];
  logic signed [CW-1:0]   c6_r [NMI_DIM][NMI_DIM];
  logic signed [LW-1:0]   pl_r [NMI_DIM];
  logic signed [LW-1:0]   ph_r [NMI_DIM];
  logic signed [DW-1:0]   t5_r [NMI_DIM];
  logic signed [DW-1:0]   det6_r;
  logic [NW-1:0]          nm7_r [NMI_ENTRIES];
  logic                   ng7_r [NMI_ENTRIES];
  logic [MW-1:0]          dm7_r;
  logic                   z7_r;

  logic                   vd_r [DL];
  logic                   zd_r [DL];
  logic [W-1:0]           q_w  [NMI_ENTRIES];
  nmi_flag_t              fl_w [NMI_ENTRIES];

  logic                   out_valid_r, skid_v_r;
  logic [W-1:0]           ob_r [NMI_ENTRIES];
  logic [W-1:0]           sb_r [NMI_ENTRIES];
  logic                   odeg_r, oovf_r, sdeg_r, sovf_r;
  logic [W-1:0]           res_b [NMI_ENTRIES];
  logic                   res_ovf;
  logic                   push, pop;
  logic                   out_valid_nxt, skid_v_nxt;

  assign en           = !skid_v_r;
  assign in_mat.ready = en && rst_n;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tr_r <= 1'b1;
    end else if (cfg_we) begin
      tr_r <= cfg_wdata;
    end
  end

  // valid bits travel with the data
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0; v2_r <= 1'b0; v3_r <= 1'b0; v4_r <= 1'b0;
      v5_r <= 1'b0; v6_r <= 1'b0; v7_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_mat.valid;
      v2_r <= v1_r; v3_r <= v2_r; v4_r <= v3_r;
      v5_r <= v4_r; v6_r <= v5_r; v7_r <= v6_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a1_r[0][0] <= in_mat.a11; a1_r[1][0] <= in_mat.a21; a1_r[2][0] <= in_mat.a31;
      a1_r[0][1] <= in_mat.a12; a1_r[1][1] <= in_mat.a22; a1_r[2][1] <= in_mat.a32;
      a1_r[0][2] <= in_mat.a13; a1_r[1][2] <= in_mat.a23; a1_r[2][2] <= in_mat.a33;
    end
  end

  // cofactor products and differences
  for (genvar gr = 0; gr < NMI_DIM; gr++) begin : g_row
    for (genvar gk = 0; gk < NMI_DIM; gk++) begin : g_col
      localparam int R1 = (gr + 1) % NMI_DIM;
      localparam int R2 = (gr + 2) % NMI_DIM;
      localparam int K1 = (gk + 1) % NMI_DIM;
      localparam int K2 = (gk + 2) % NMI_DIM;
      always_ff @(posedge clk) begin
        if (en) begin
          p1_r[gr][gk] <= a1_r[R1][K1] * a1_r[R2][K2];
          p2_r[gr][gk] <= a1_r[R1][K2] * a1_r[R2][K1];
          c3_r[gr][gk] <= CW'(p1_r[gr][gk]) - CW'(p2_r[gr][gk]);
          c4_r[gr][gk] <= c3_r[gr][gk];
          c5_r[gr][gk] <= c4_r[gr][gk];
          c6_r[gr][gk] <= c5_r[gr][gk];
        end
      end
    end
  end

  // determinant along row one, each wide product split in two halves
  for (genvar gk = 0; gk < NMI_DIM; gk++) begin : g_det
    logic signed [W:0] c_lo;
    logic signed [W:0] c_hi;
    assign c_lo = $signed({1'b0, c3_r[0][gk][W-1:0]});
    assign c_hi = $signed(c3_r[0][gk][CW-1:W]);
    always_ff @(posedge clk) begin
      if (en) begin
        a2_r[gk] <= a1_r[0][gk];
        a3_r[gk] <= a2_r[gk];
        pl_r[gk] <= a3_r[gk] * c_lo;
        ph_r[gk] <= a3_r[gk] * c_hi;
        t5_r[gk] <= DW'(pl_r[gk]) + (DW'(ph_r[gk]) <<< W);
      end
    end
  end

  logic signed [DW-1:0] det_abs;
  assign det_abs = det6_r[DW-1] ? -det6_r : det6_r;

  always_ff @(posedge clk) begin
    if (en) begin
      det6_r <= t5_r[0] + t5_r[1] + t5_r[2];
      dm7_r  <= det_abs[MW-1:0];
      z7_r   <= (det6_r == '0);
    end
  end

  // numerator select and sign per result entry
  for (genvar ge = 0; ge < NMI_ENTRIES; ge++) begin : g_num
    localparam int ROW = ge % NMI_DIM;
    localparam int COL = ge / NMI_DIM;
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] xa;
    assign x  = tr_r ? c6_r[ROW][COL] : c6_r[COL][ROW];
    assign xa = x[CW-1] ? -x : x;
    always_ff @(posedge clk) begin
      if (en) begin
        nm7_r[ge] <= xa[NW-1:0];
        ng7_r[ge] <= x[CW-1] ^ det6_r[DW-1];
      end
    end
    nmi_div #(.ELEM_WIDTH(ELEM_WIDTH), .FRAC_BITS(FRAC_BITS)) u_div (
      .clk  (clk),
      .en   (en),
      .num  (nm7_r[ge]),
      .den  (dm7_r),
      .neg  (ng7_r[ge]),
      .quo  (q_w[ge]),
      .flag (fl_w[ge])
    );
    assign res_b[ge] = zd_r[DL-1] ? ((ROW == COL) ? ONE_Q : '0) : q_w[ge];
  end

  for (genvar gd = 0; gd < DL; gd++) begin : g_dly
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vd_r[gd] <= 1'b0;
      end else if (en) begin
        vd_r[gd] <= (gd == 0) ? v7_r : vd_r[(gd == 0) ? 0 : gd-1];
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        zd_r[gd] <= (gd == 0) ? z7_r : zd_r[(gd == 0) ? 0 : gd-1];
      end
    end
  end

  always_comb begin
    res_ovf = 1'b0;
    for (int i = 0; i < NMI_ENTRIES; i++) begin
      res_ovf = res_ovf | fl_w[i].sat;
    end
    if (zd_r[DL-1]) begin
      res_ovf = ID_OVF;
    end
  end

  // output word register with one skid entry
  assign push = en && vd_r[DL-1];
  assign pop  = out_valid_r && out_res.ready;

  always_comb begin
    out_valid_nxt = out_valid_r;
    skid_v_nxt    = skid_v_r;
    if (skid_v_r) begin
      if (pop) begin
        skid_v_nxt = 1'b0;
      end
    end else if (push) begin
      out_valid_nxt = 1'b1;
      if (out_valid_r && !pop) begin
        skid_v_nxt = 1'b1;
      end
    end else if (pop) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      skid_v_r    <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      skid_v_r    <= skid_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_v_r) begin
      if (pop) begin
        ob_r   <= sb_r;
        odeg_r <= sdeg_r;
        oovf_r <= sovf_r;
      end
    end else if (push) begin
      if (!out_valid_r || pop) begin
        ob_r   <= res_b;
        odeg_r <= zd_r[DL-1];
        oovf_r <= res_ovf;
      end else begin
        sb_r   <= res_b;
        sdeg_r <= zd_r[DL-1];
        sovf_r <= res_ovf;
      end
    end
  end

  assign out_res.valid      = out_valid_r;
  assign out_res.b11        = ob_r[0];
  assign out_res.b21        = ob_r[1];
  assign out_res.b31        = ob_r[2];
  assign out_res.b12        = ob_r[3];
  assign out_res.b22        = ob_r[4];
  assign out_res.b32        = ob_r[5];
  assign out_res.b13        = ob_r[6];
  assign out_res.b23        = ob_r[7];
  assign out_res.b33        = ob_r[8];
  assign out_res.degenerate = odeg_r;
  assign out_res.overflow   = oovf_r;

  `NMI_ASSERT_NOW(a_skid_needs_main, skid_v_r, out_valid_r)
  `NMI_ASSERT_NEXT(a_skid_holds, skid_v_r && !out_res.ready, skid_v_r && out_valid_r)
  `NMI_ASSERT_NOW(a_degen_diag, out_valid_r && odeg_r, ob_r[4] == ONE_Q && ob_r[1] == '0)

endmodule

FILE: tb/normal_matrix_inverse_3x3_tb.sv
// self-checking testbench for the 3x3 inverse / normal matrix block
module normal_matrix_inverse_3x3_tb;
  import nmi_pkg::*;

  localparam int EW = 32;
  localparam int FB = 16;

  typedef logic signed [EW-1:0] elem_t;
  typedef logic signed [159:0] big_t;
  typedef struct {
    elem_t e [9];
    logic  degenerate;
    logic  overflow;
  } inv_word_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic cfg_wdata = 1'b0;

  nmi_mat_if #(.ELEM_WIDTH(EW)) in_if ();
  nmi_res_if #(.ELEM_WIDTH(EW)) out_if ();

  normal_matrix_inverse_3x3 #(.ELEM_WIDTH(EW), .FRAC_BITS(FB)) u_dut (
    .clk(clk), .rst_n(rst_n), .in_mat(in_if.sink), .out_res(out_if.source),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  always #2 clk = ~clk;

  logic      transpose_sel = 1'b1;
  inv_word_t inverse_q [$];
  int        n_errors = 0;
  int        n_sent = 0;
  int        n_checked = 0;
  int        n_degen = 0;
  int        n_ovf = 0;
  bit        quiet = 1'b0;
  int        hold_off = 0;

  // exact rounded, saturated x * 2^(2F) / det
  function automatic elem_t div_entry(big_t x, big_t det, ref logic ovf);
    logic neg;
    logic [159:0] n, d, q, rem;
    neg = x[159] ^ det[159];
    n = x[159] ? -x : x;
    d = det[159] ? -det : det;
    n = n << (2 * FB);
    q = n / d;
    rem = n % d;
    if ((rem << 1) >= d) q = q + 1;
    if (!neg) begin
      if (q > 160'h7fffffff) begin
        ovf = 1'b1;
        return 32'sh7fffffff;
      end
      return q[31:0];
    end
    if (q > 160'h80000000) begin
      ovf = 1'b1;
      return 32'sh80000000;
    end
    return -q[31:0];
  endfunction

  function automatic inv_word_t inverse_of(elem_t m [9]);
    big_t a [3][3];
    big_t c [3][3];
    big_t det;
    inv_word_t r;
    logic ovf;
    ovf = 1'b0;
    for (int k = 0; k < 9; k++) a[k % 3][k / 3] = m[k];
    for (int i = 0; i < 3; i++)
      for (int j = 0; j < 3; j++)
        c[i][j] = a[(i+1)%3][(j+1)%3] * a[(i+2)%3][(j+2)%3]
                - a[(i+1)%3][(j+2)%3] * a[(i+2)%3][(j+1)%3];
    det = a[0][0] * c[0][0] + a[0][1] * c[0][1] + a[0][2] * c[0][2];
    if (det == 0) begin
      for (int k = 0; k < 9; k++) r.e[k] = (k % 3 == k / 3) ? elem_t'(1 << FB) : '0;
      r.degenerate = 1'b1;
      r.overflow = 1'b0;
      return r;
    end
    for (int k = 0; k < 9; k++)
      r.e[k] = div_entry(transpose_sel ? c[k % 3][k / 3] : c[k / 3][k % 3], det, ovf);
    r.degenerate = 1'b0;
    r.overflow = ovf;
    return r;
  endfunction

  task automatic send_matrix(elem_t m [9]);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      @(negedge clk);
      in_if.valid = 1'b0;
      repeat ($urandom_range(1, 5) - 1) @(negedge clk);
    end
    @(negedge clk);
    {in_if.a11, in_if.a21, in_if.a31} = {m[0], m[1], m[2]};
    {in_if.a12, in_if.a22, in_if.a32} = {m[3], m[4], m[5]};
    {in_if.a13, in_if.a23, in_if.a33} = {m[6], m[7], m[8]};
    in_if.valid = 1'b1;
    do @(posedge clk); while (!in_if.ready);
    inverse_q.push_back(inverse_of(m));
    n_sent++;
  endtask

  task automatic drain();
    @(negedge clk);
    in_if.valid = 1'b0;
    wait (inverse_q.size() == 0);
    repeat (60) @(negedge clk);
  endtask

  task automatic write_transpose(logic v);
    drain();
    cfg_we = 1'b1;
    cfg_wdata = v;
    @(negedge clk);
    cfg_we = 1'b0;
    transpose_sel = v;
  endtask

  task automatic report_mismatch(string what, elem_t got, elem_t want);
    $display("mismatch %s: got %h want %h", what, got, want);
    n_errors++;
  endtask

  // receiver ready, random stall bursts unless quiet or held off
  initial begin
    int burst;
    out_if.ready = 1'b0;
    burst = 0;
    forever begin
      @(negedge clk);
      if (hold_off > 0) begin
        out_if.ready = 1'b0;
        hold_off--;
      end else if (burst > 0) begin
        out_if.ready = 1'b0;
        burst--;
      end else begin
        out_if.ready = 1'b1;
        if (!quiet && $urandom_range(0, 4) == 0) burst = $urandom_range(1, 5);
      end
    end
  end

  always @(posedge clk) begin
    inv_word_t want;
    elem_t got [9];
    if (rst_n && out_if.valid && out_if.ready) begin
      got = '{out_if.b11, out_if.b21, out_if.b31, out_if.b12, out_if.b22,
              out_if.b32, out_if.b13, out_if.b23, out_if.b33};
      if (inverse_q.size() == 0) begin
        $display("result word with nothing expected");
        n_errors++;
      end else begin
        want = inverse_q.pop_front();
        for (int k = 0; k < 9; k++)
          if (got[k] !== want.e[k]) report_mismatch($sformatf("b%0d%0d", k % 3 + 1, k / 3 + 1),
                                                    got[k], want.e[k]);
        if (out_if.degenerate !== want.degenerate)
          report_mismatch("degenerate", out_if.degenerate, want.degenerate);
        if (out_if.overflow !== want.overflow)
          report_mismatch("overflow", out_if.overflow, want.overflow);
        n_checked++;
        n_degen += want.degenerate;
        n_ovf += want.overflow;
      end
    end
  end

  function automatic elem_t rnd_small();
    return elem_t'($urandom_range(0, 2 ** 19)) - elem_t'(2 ** 18);
  endfunction

  // mostly well-conditioned Q16.16 matrices, plus full-range, singular and tiny ones
  function automatic void random_matrix(output elem_t m [9]);
    int kind;
    kind = $urandom_range(0, 9);
    for (int k = 0; k < 9; k++) begin
      case (kind)
        0, 1:    m[k] = $urandom();
        2:       m[k] = elem_t'($urandom_range(0, 6)) - 3;
        default: m[k] = rnd_small();
      endcase
      if (kind >= 5 && k % 4 == 0) m[k] = m[k] + elem_t'($urandom_range(1, 8) << FB);
    end
    // singular: one row a copy or a multiple of another
    if (kind == 3)
      for (int c = 0; c < 3; c++) m[2 + 3 * c] = m[3 * c];
    if (kind == 4)
      for (int c = 0; c < 3; c++) m[1 + 3 * c] = m[3 * c] * 2;
  endfunction

  task automatic test_directed();
    elem_t one, mx, mn;
    elem_t m [9];
    one = 1 << FB;
    mx = 32'sh7fffffff;
    mn = 32'sh80000000;
    send_matrix('{one, 0, 0, 0, one, 0, 0, 0, one});
    send_matrix('{0, 0, 0, 0, 0, 0, 0, 0, 0});
    send_matrix('{1, 0, 0, 0, 1, 0, 0, 0, 1});
    send_matrix('{-1, 0, 0, 0, 1, 0, 0, 0, 1});
    send_matrix('{mx, 0, 0, 0, mx, 0, 0, 0, mx});
    send_matrix('{mn, 0, 0, 0, mn, 0, 0, 0, mn});
    send_matrix('{mx, mx, mx, mx, mx, mx, mx, mx, mx});
    send_matrix('{mn, mx, mn, mx, mn, mx, mn, mx, mx});
    send_matrix('{mn, 0, 0, 0, mx, 0, 0, 0, 1});
    send_matrix('{2 * one, 0, 0, 0, 4 * one, 0, 0, 0, -8 * one});
    send_matrix('{0, one, 0, 0, 0, one, one, 0, 0});
    send_matrix('{one, 2 * one, 3 * one, 4 * one, 5 * one, 6 * one,
                  7 * one, 8 * one, 10 * one});
    send_matrix('{one, 2 * one, 3 * one, 4 * one, 5 * one, 6 * one,
                  7 * one, 8 * one, 9 * one});
    // rounding of inexact quotients: plus and minus 1/3 of a unit
    send_matrix('{3 * one, 0, 0, 0, 3 * one, 0, 0, 0, -3 * one});
    send_matrix('{3, 0, 0, 0, 2, 0, 0, 0, 1});
    send_matrix('{one, one, 0, 0, one, one, one, 0, one});
    send_matrix('{0, 0, 0, one, one, one, 2 * one, 3 * one, 4 * one});
    send_matrix('{one / 2, 0, 0, 0, one, 0, 0, 0, one * 2});
    for (int k = 0; k < 9; k++) m[k] = (k % 2) ? mx : mn;
    send_matrix(m);
  endtask

  task automatic test_random(int count);
    elem_t m [9];
    repeat (count) begin
      random_matrix(m);
      send_matrix(m);
    end
  endtask

  task automatic test_backpressure();
    elem_t m [9];
    hold_off = 300;
    for (int i = 0; i < 100; i++) begin
      random_matrix(m);
      send_matrix(m);
    end
    drain();
  endtask

  initial begin
    in_if.valid = 1'b0;
    {in_if.a11, in_if.a21, in_if.a31, in_if.a12, in_if.a22,
     in_if.a32, in_if.a13, in_if.a23, in_if.a33} = '0;
    repeat (9) @(negedge clk);
    rst_n = 1'b1;
    test_directed();
    test_random(580);
    write_transpose(1'b0);
    test_directed();
    test_random(580);
    write_transpose(1'b1);
    test_backpressure();
    write_transpose(1'b0);
    test_random(200);
    quiet = 1'b1;
    test_random(350);
    drain();
    $display("sent %0d matrices over both output modes, checked %0d words", n_sent, n_checked);
    $display("%0d singular inputs, %0d words with saturation", n_degen, n_ovf);
    if (n_errors == 0 && inverse_q.size() == 0) begin
      $display("normal_matrix_inverse_3x3_tb: done, clean");
    end else begin
      $display("normal_matrix_inverse_3x3_tb: done, errors");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("timeout");
    $display("normal_matrix_inverse_3x3_tb: done, errors");
    $finish;
  end

endmodule
